// File: rtl/fcd_pkg.sv
// Shared constants and types for the fraction common denominator block.
package fcd_pkg;

	// Default width of the numerator and denominator inputs.
	localparam int unsigned DATA_WIDTH_DEF = 16;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// File: rtl/fcd_div.sv
// Shared restoring divider, one quotient bit per cycle.
module fcd_div #(
	parameter int unsigned DATA_WIDTH = fcd_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output fcd_pkg::div_sts_t     sts,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);
	import fcd_pkg::*;

	localparam int unsigned CW = $clog2(DATA_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;

	// Shift the next dividend bit into the partial remainder and try a subtraction.
	always_comb begin
		trial = {rem_q, dvd_q[DATA_WIDTH-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = (trial >= {1'b0, dsr_q});
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operand registers; quotient bits enter the dividend register from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], fits};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	// A new division is never started while one is running.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	// The remainder is reduced below a nonzero divisor once the division ends.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (dsr_q != '0)) |-> (rem_q < dsr_q))
		else $error("divider remainder not reduced");

	// Completion follows a busy period and leaves the unit idle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("divider done without a busy period");

endmodule

// File: rtl/fcd_mul.sv
// Registered signed multiplier shared by the scaling steps.
module fcd_mul #(
	parameter int unsigned DATA_WIDTH = fcd_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic signed [DATA_WIDTH:0]     op_a,
	input  logic signed [DATA_WIDTH:0]     op_b,
	output logic signed [2*DATA_WIDTH+1:0] prod
);

	logic signed [2*DATA_WIDTH+1:0] prod_q;

	// Product is registered before any further use.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// File: rtl/fraction_common_denominator_top.sv
// Top level of the fraction common denominator block: sequencer, datapath and output register.
//
// Usage: a request carries two signed fractions first_num/first_den and
// second_num/second_den on the input channel (in_valid, in_stall). The result
// carries both numerators rescaled over the positive least common multiple of
// the denominator magnitudes, that multiple, and an error flag, on the output
// channel (out_valid, out_stall).
// One request is worked on at a time and in_stall is high while it is. The
// greatest common divisor is found by Euclid's remainder steps on a single
// shared divider that yields one quotient bit per cycle. Two further
// divisions by the divisor and three products on a registered multiplier
// follow. The Euclid loop of a request takes k remainder steps, where k
// ranges from 1 to roughly 1.5*DATA_WIDTH. A zero denominator skips the
// arithmetic and goes straight to the result state. The result sits in an
// output register; a stalled receiver holds it there and the block may
// finish the next request into that register only once it has been taken.
// Reset clears the sequencer and the output valid flag.
module fraction_common_denominator_top #(
	parameter int unsigned DATA_WIDTH = fcd_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [DATA_WIDTH-1:0]   first_num,
	input  logic signed [DATA_WIDTH-1:0]   first_den,
	input  logic signed [DATA_WIDTH-1:0]   second_num,
	input  logic signed [DATA_WIDTH-1:0]   second_den,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [2*DATA_WIDTH-2:0] first_num_scaled,
	output logic signed [2*DATA_WIDTH-2:0] second_num_scaled,
	output logic [2*DATA_WIDTH-3:0]        common_den,
	output logic                           zero_den_error
);
	import fcd_pkg::*;

	localparam int unsigned NW = 2 * DATA_WIDTH - 1;
	localparam int unsigned DW = 2 * DATA_WIDTH - 2;
	localparam int unsigned PW = 2 * DATA_WIDTH + 2;
	localparam logic signed [PW-1:0] SAT_HI = {{(PW-NW+1){1'b0}}, {(NW-1){1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GCD,
		ST_GCD_WAIT,
		ST_DIV1,
		ST_DIV1_WAIT,
		ST_DIV2,
		ST_DIV2_WAIT,
		ST_MUL_L,
		ST_MUL_1,
		ST_MUL_2,
		ST_MUL_END,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic                         out_valid_q;
	logic signed [NW-1:0]         first_num_scaled_q;
	logic signed [NW-1:0]         second_num_scaled_q;
	logic [DW-1:0]                common_den_q;
	logic                         zero_den_error_q;

	logic signed [DATA_WIDTH-1:0] n1_q;
	logic signed [DATA_WIDTH-1:0] n2_q;
	logic                         neg1_q;
	logic                         neg2_q;
	logic                         err_q;
	logic [DATA_WIDTH-1:0]        m1_q;
	logic [DATA_WIDTH-1:0]        m2_q;
	logic [DATA_WIDTH-1:0]        p_q;
	logic [DATA_WIDTH-1:0]        q_q;
	logic [DATA_WIDTH-1:0]        q1_q;
	logic [DATA_WIDTH-1:0]        q2_q;
	logic [DW-1:0]                lcm_q;
	logic signed [PW-1:0]         s1_q;
	logic signed [PW-1:0]         s2_q;

	logic                         accept;
	logic                         err_in;
	logic [DATA_WIDTH-1:0]        mag1;
	logic [DATA_WIDTH-1:0]        mag2;
	logic                         div_start;
	logic [DATA_WIDTH-1:0]        div_dvd;
	logic [DATA_WIDTH-1:0]        div_dsr;
	div_sts_t                     div_sts;
	logic [DATA_WIDTH-1:0]        div_quot;
	logic [DATA_WIDTH-1:0]        div_rem;
	logic signed [DATA_WIDTH:0]   mul_a;
	logic signed [DATA_WIDTH:0]   mul_b;
	logic signed [PW-1:0]         mul_prod;
	logic signed [PW-1:0]         v1;
	logic signed [PW-1:0]         v2;
	logic                         out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Denominator magnitudes and the zero check on the incoming request.
	always_comb begin
		mag1   = first_den[DATA_WIDTH-1] ? DATA_WIDTH'(~first_den + 1'b1) : unsigned'(first_den);
		mag2   = second_den[DATA_WIDTH-1] ? DATA_WIDTH'(~second_den + 1'b1) :
			unsigned'(second_den);
		err_in = (first_den == '0) || (second_den == '0);
	end

	// Divider operand selection: Euclid steps, then the two cofactors.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = p_q;
		div_dsr   = q_q;
		unique case (state_q)
			ST_GCD: begin
				div_start = (q_q != '0);
			end
			ST_DIV1: begin
				div_start = 1'b1;
				div_dvd   = m1_q;
				div_dsr   = p_q;
			end
			ST_DIV2: begin
				div_start = 1'b1;
				div_dvd   = m2_q;
				div_dsr   = p_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Multiplier operand selection: the multiple, then each numerator times its cofactor.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_L: begin
				mul_a = {1'b0, q1_q};
				mul_b = {1'b0, m2_q};
			end
			ST_MUL_1: begin
				mul_a = {n1_q[DATA_WIDTH-1], n1_q};
				mul_b = {1'b0, q2_q};
			end
			ST_MUL_2: begin
				mul_a = {n2_q[DATA_WIDTH-1], n2_q};
				mul_b = {1'b0, q1_q};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Sign folding and saturation of the single overflowing case.
	always_comb begin
		v1 = neg1_q ? -s1_q : s1_q;
		v2 = neg2_q ? -s2_q : s2_q;
		if (v1 > SAT_HI) begin
			v1 = SAT_HI;
		end
		if (v2 > SAT_HI) begin
			v2 = SAT_HI;
		end
	end

	fcd_div #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.sts      (div_sts),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	fcd_mul #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mul (
		.clk (clk),
		.op_a(mul_a),
		.op_b(mul_b),
		.prod(mul_prod)
	);

	// Sequencer state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			out_valid_q         <= 1'b0;
			first_num_scaled_q  <= '0;
			second_num_scaled_q <= '0;
			common_den_q        <= '0;
			zero_den_error_q    <= 1'b0;
		end else begin
			// A taken result empties the register unless a new one lands at once.
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= err_in ? ST_FIN : ST_GCD;
					end
				end
				ST_GCD: begin
					state_q <= (q_q == '0) ? ST_DIV1 : ST_GCD_WAIT;
				end
				ST_GCD_WAIT: begin
					if (div_sts.done) begin
						state_q <= ST_GCD;
					end
				end
				ST_DIV1: begin
					state_q <= ST_DIV1_WAIT;
				end
				ST_DIV1_WAIT: begin
					if (div_sts.done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					state_q <= ST_DIV2_WAIT;
				end
				ST_DIV2_WAIT: begin
					if (div_sts.done) begin
						state_q <= ST_MUL_L;
					end
				end
				ST_MUL_L: begin
					state_q <= ST_MUL_1;
				end
				ST_MUL_1: begin
					state_q <= ST_MUL_2;
				end
				ST_MUL_2: begin
					state_q <= ST_MUL_END;
				end
				ST_MUL_END: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						first_num_scaled_q  <= err_q ? '0 : v1[NW-1:0];
						second_num_scaled_q <= err_q ? '0 : v2[NW-1:0];
						common_den_q        <= err_q ? '0 : lcm_q;
						zero_den_error_q    <= err_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n1_q   <= first_num;
					n2_q   <= second_num;
					neg1_q <= first_den[DATA_WIDTH-1];
					neg2_q <= second_den[DATA_WIDTH-1];
					err_q  <= err_in;
					m1_q   <= mag1;
					m2_q   <= mag2;
					p_q    <= mag1;
					q_q    <= mag2;
				end
			end
			ST_GCD_WAIT: begin
				if (div_sts.done) begin
					p_q <= q_q;
					q_q <= div_rem;
				end
			end
			ST_DIV1_WAIT: begin
				if (div_sts.done) begin
					q1_q <= div_quot;
				end
			end
			ST_DIV2_WAIT: begin
				if (div_sts.done) begin
					q2_q <= div_quot;
				end
			end
			ST_MUL_1: begin
				lcm_q <= mul_prod[DW-1:0];
			end
			ST_MUL_2: begin
				s1_q <= mul_prod;
			end
			ST_MUL_END: begin
				s2_q <= mul_prod;
			end
			default: begin
				lcm_q <= lcm_q;
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign first_num_scaled  = first_num_scaled_q;
	assign second_num_scaled = second_num_scaled_q;
	assign common_den        = common_den_q;
	assign zero_den_error    = zero_den_error_q;

	// A flagged result carries zeros in every other field.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_den_error) |->
		((common_den == '0) && (first_num_scaled == '0) && (second_num_scaled == '0)))
		else $error("error result with nonzero fields");

	// A good result always has a nonzero common denominator.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !zero_den_error) |-> (common_den != '0))
		else $error("zero common denominator without error");

	// Divider completion is only seen while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |->
		((state_q == ST_GCD_WAIT) || (state_q == ST_DIV1_WAIT) || (state_q == ST_DIV2_WAIT)))
		else $error("divider completion outside a wait state");

	// A division is only started while the divider is idle.
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("division started while the divider is busy");

	// An accepted request starts Euclid's loop or goes straight to the error result.
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == ST_GCD) || (state_q == ST_FIN)))
		else $error("unexpected state after accepting a request");

endmodule

// File: dv/fraction_common_denominator_top_tb.sv
// Self-checking testbench: directed table of fraction pairs, then random requests.
`timescale 1ns / 100ps

module fraction_common_denominator_top_tb;

	localparam int DW = fcd_pkg::DATA_WIDTH_DEF;
	localparam int SW = 2 * DW - 1;
	localparam int LW = 2 * DW - 2;
	localparam longint SCALED_MAX = (longint'(1) << (2 * DW - 2)) - 1;
	localparam int MOST_NEG = -(1 << (DW - 1));
	localparam int MOST_POS = (1 << (DW - 1)) - 1;
	localparam int N_RANDOM = 1250;
	localparam int N_DIRECTED = 24;
	// Longest Euclid run is about 1.5*DW remainder steps.
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES = 2500;

	typedef struct {
		logic signed [DW-1:0] first_num;
		logic signed [DW-1:0] first_den;
		logic signed [DW-1:0] second_num;
		logic signed [DW-1:0] second_den;
	} fraction_pair_t;

	typedef struct {
		logic signed [SW-1:0] first_scaled;
		logic signed [SW-1:0] second_scaled;
		logic [LW-1:0]        lcm;
		logic                 zero_den;
	} common_form_t;

	typedef struct {
		int n1;
		int d1;
		int n2;
		int d2;
		bit typed;
		int e1;
		int e2;
		int elcm;
		bit eerr;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [DW-1:0] first_num = '0;
	logic signed [DW-1:0] first_den = '0;
	logic signed [DW-1:0] second_num = '0;
	logic signed [DW-1:0] second_den = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] first_num_scaled;
	logic signed [SW-1:0] second_num_scaled;
	logic [LW-1:0]        common_den;
	logic                 zero_den_error;

	common_form_t expected_forms[$];
	int unsigned  mismatch_count = 0;
	int unsigned  results_taken = 0;
	logic         hold_off = 1'b0;

	// Directed table: typed rows carry their result, the others go through the predictor.
	directed_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{1, 0, 1, 1, 1'b1, 0, 0, 0, 1'b1},
		'{5, 3, 7, 0, 1'b1, 0, 0, 0, 1'b1},
		'{0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b1},
		'{MOST_NEG, 0, MOST_POS, MOST_NEG, 1'b1, 0, 0, 0, 1'b1},
		'{MOST_POS, -MOST_POS, MOST_NEG, 0, 1'b1, 0, 0, 0, 1'b1},
		'{1, 1, 1, 1, 1'b1, 1, 1, 1, 1'b0},
		'{3, 4, 5, 4, 1'b1, 3, 5, 4, 1'b0},
		'{3, -4, 5, 4, 1'b1, -3, 5, 4, 1'b0},
		'{MOST_NEG, -1, 1, -1, 1'b1, 32768, -1, 1, 1'b0},
		'{MOST_NEG, -1, MOST_NEG, MOST_NEG, 1'b1, 1073741823, 32768, 32768, 1'b0},
		'{MOST_NEG, -MOST_POS, MOST_POS, MOST_NEG,
			1'b1, 1073741823, -1073676289, 1073709056, 1'b0},
		'{MOST_NEG, 1, MOST_NEG, MOST_NEG, 1'b1, -1073741824, 32768, 32768, 1'b0},
		'{MOST_POS, MOST_POS, -MOST_POS, 32766, 1'b0, 0, 0, 0, 1'b0},
		'{0, 5, 0, -5, 1'b1, 0, 0, 5, 1'b0},
		'{1, 6, 1, 4, 1'b0, 0, 0, 0, 1'b0},
		'{7, -12, -5, 18, 1'b0, 0, 0, 0, 1'b0},
		'{12, -35, 9, 48, 1'b0, 0, 0, 0, 1'b0},
		'{100, 28657, -100, 17711, 1'b0, 0, 0, 0, 1'b0},
		'{-1, -17711, 1, -28657, 1'b0, 0, 0, 0, 1'b0},
		'{MOST_POS, MOST_NEG, -MOST_POS, -1, 1'b0, 0, 0, 0, 1'b0},
		'{-1, 1, -1, 1, 1'b1, -1, -1, 1, 1'b0},
		'{MOST_POS, 1, -MOST_POS, 1, 1'b1, 32767, -32767, 1, 1'b0},
		'{5, -7, -3, -7, 1'b1, -5, 3, 7, 1'b0},
		'{1234, -360, -4321, 1024, 1'b0, 0, 0, 0, 1'b0}
	};

	fraction_common_denominator_top #(
		.DATA_WIDTH(DW)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.first_num        (first_num),
		.first_den        (first_den),
		.second_num       (second_num),
		.second_den       (second_den),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.first_num_scaled (first_num_scaled),
		.second_num_scaled(second_num_scaled),
		.common_den       (common_den),
		.zero_den_error   (zero_den_error)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Greatest common divisor by repeated remainders.
	function automatic longint unsigned euclid_gcd(longint unsigned p, longint unsigned q);
		longint unsigned r;
		while (q != 0) begin
			r = p % q;
			p = q;
			q = r;
		end
		return p;
	endfunction

	// Numerator over the common denominator, with the denominator sign folded in.
	function automatic logic signed [SW-1:0] rescale_num(longint num, longint den,
			longint unsigned lcm);
		longint unsigned mag;
		longint          prod;
		mag = (den < 0) ? longint'(-den) : longint'(den);
		prod = num * longint'(lcm / mag);
		if (den < 0)
			prod = -prod;
		if (prod > SCALED_MAX)
			prod = SCALED_MAX;
		return prod[SW-1:0];
	endfunction

	// Predicts the common-denominator form of one request.
	function automatic common_form_t common_form(fraction_pair_t pair);
		common_form_t    res;
		longint          d1;
		longint          d2;
		longint unsigned m1;
		longint unsigned m2;
		longint unsigned lcm;
		d1 = longint'(pair.first_den);
		d2 = longint'(pair.second_den);
		res.first_scaled = '0;
		res.second_scaled = '0;
		res.lcm = '0;
		res.zero_den = 1'b1;
		if (d1 == 0 || d2 == 0)
			return res;
		m1 = (d1 < 0) ? -d1 : d1;
		m2 = (d2 < 0) ? -d2 : d2;
		lcm = (m1 / euclid_gcd(m1, m2)) * m2;
		res.first_scaled = rescale_num(longint'(pair.first_num), d1, lcm);
		res.second_scaled = rescale_num(longint'(pair.second_num), d2, lcm);
		res.lcm = lcm[LW-1:0];
		res.zero_den = 1'b0;
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 300);
	endfunction

	function automatic logic signed [DW-1:0] random_numerator();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return DW'(MOST_NEG);
		if (r < 10)
			return DW'(MOST_POS);
		if (r < 14)
			return '0;
		return DW'($urandom());
	endfunction

	// Denominators lean towards zero, the extremes and small values.
	function automatic logic signed [DW-1:0] random_denominator();
		int unsigned r;
		int          mag;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 9)
			return DW'(MOST_NEG);
		if (r < 35) begin
			mag = (r < 13) ? MOST_POS : $urandom_range(1, 24);
			return $urandom_range(0, 1) ? DW'(mag) : DW'(-mag);
		end
		return DW'($urandom());
	endfunction

	function automatic fraction_pair_t random_pair();
		fraction_pair_t pair;
		pair.first_num = random_numerator();
		pair.first_den = random_denominator();
		pair.second_num = random_numerator();
		pair.second_den = random_denominator();
		// Equal magnitudes now and then, either sign.
		if ($urandom_range(0, 9) == 0)
			pair.second_den = $urandom_range(0, 1) ? pair.first_den : -pair.first_den;
		return pair;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offers one request after an optional gap and records its expected result on acceptance.
	task automatic send_request(fraction_pair_t pair, bit calm, bit typed, common_form_t typed_res);
		int unsigned gap;
		gap = calm ? 0 : idle_length();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_num <= pair.first_num;
		first_den <= pair.first_den;
		second_num <= pair.second_num;
		second_den <= pair.second_den;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_forms.push_back(typed ? typed_res : common_form(pair));
	endtask

	// Reset, directed table, random requests, then drain and verdict.
	initial begin : stimulus
		fraction_pair_t pair;
		common_form_t   typed_res;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			pair.first_num = DW'(directed_rows[i].n1);
			pair.first_den = DW'(directed_rows[i].d1);
			pair.second_num = DW'(directed_rows[i].n2);
			pair.second_den = DW'(directed_rows[i].d2);
			typed_res.first_scaled = SW'(directed_rows[i].e1);
			typed_res.second_scaled = SW'(directed_rows[i].e2);
			typed_res.lcm = LW'(directed_rows[i].elcm);
			typed_res.zero_den = directed_rows[i].eerr;
			send_request(pair, i < 8, directed_rows[i].typed, typed_res);
		end
		for (int i = 0; i < N_RANDOM; i++)
			send_request(random_pair(), (i / 150) % 3 == 1, 1'b0, typed_res);
		in_valid <= 1'b0;
		while (expected_forms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Long receiver hold-off, twice, so that the block fills up and stalls its input.
	initial begin : receiver_hold
		wait (results_taken >= 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
		wait (results_taken >= 700);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Result checking and random receiver stalls, with calm stretches between busy ones.
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	bit          calm = 1'b0;

	always @(posedge clk) begin : result_check
		common_form_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_taken++;
				if (expected_forms.size() == 0) begin
					report_mismatch("result with no request waiting", 0, 0);
				end else begin
					want = expected_forms.pop_front();
					if (first_num_scaled !== want.first_scaled)
						report_mismatch("first_num_scaled", first_num_scaled, want.first_scaled);
					if (second_num_scaled !== want.second_scaled)
						report_mismatch("second_num_scaled", second_num_scaled,
							want.second_scaled);
					if (common_den !== want.lcm)
						report_mismatch("common_den", common_den, want.lcm);
					if (zero_den_error !== want.zero_den)
						report_mismatch("zero_den_error", zero_den_error, want.zero_den);
				end
			end
			if (calm_left == 0) begin
				calm = !calm;
				calm_left = $urandom_range(200, 1500);
			end else begin
				calm_left--;
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 5) begin
				stall_left = idle_length();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog against a hung block.
	initial begin : watchdog
		#45_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
